>>> design/vgfc_pkg.sv
package vgfc_pkg;

    localparam int XZ_SIZE    = 16;
    localparam int Y_SIZE     = 128;
    localparam int XZ_W       = $clog2(XZ_SIZE);
    localparam int Y_W        = $clog2(Y_SIZE);
    localparam int CELL_COUNT = XZ_SIZE * XZ_SIZE * Y_SIZE;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam int MODE_W     = 2;
    localparam int CX_W       = 4;
    localparam int CY_W       = 7;
    localparam int CZ_W       = 4;
    localparam int MAT_W      = 7;
    localparam int IDX_W      = 15;
    localparam int MASK_W     = 6;
    localparam int CFG_IDX_W  = 2;

    localparam int NBR_N      = 6;
    localparam int NBR_W      = $clog2(NBR_N);

    typedef enum logic [MODE_W-1:0] {
        MODE_PLACE,
        MODE_REMOVE,
        MODE_QUERY,
        MODE_READ
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMPTY,
        CFG_WATER
    } t_cfg_idx;

    typedef logic [NBR_W-1:0]  t_face;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_face FACE_TOP = NBR_W'(0);
    localparam t_face FACE_BOT = NBR_W'(1);
    localparam t_face FACE_PX  = NBR_W'(2);
    localparam t_face FACE_NX  = NBR_W'(3);
    localparam t_face FACE_PZ  = NBR_W'(4);
    localparam t_face FACE_NZ  = NBR_W'(5);

    typedef struct packed {
        t_addr                   ctr;
        t_addr [NBR_N-1:0]       addr;
        logic  [NBR_N-1:0]       inb;
        logic                    top_edge;
    } t_nbr;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CUR,
        ST_TOP,
        ST_BOT,
        ST_PX,
        ST_NX,
        ST_PZ,
        ST_NZ,
        ST_WR,
        ST_OUT
    } t_step;

    typedef enum logic [1:0] {
        ASEL_IN,
        ASEL_CUR,
        ASEL_NBR
    } t_asel;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ACCEPT,
        JMP_MODE,
        JMP_GOTO,
        JMP_OUT
    } t_jmp;

    typedef struct packed {
        t_asel asel;
        t_face nbr;
        logic  cap_cur;
        logic  cap_face;
        t_face face;
        logic  wr;
        logic  out;
        t_jmp  jmp;
        t_step target;
    } t_uop;

    function automatic t_uop uop_rom(t_step s);
        t_uop u;
        u = '{asel: ASEL_CUR, nbr: FACE_TOP, cap_cur: 1'b0, cap_face: 1'b0,
              face: FACE_TOP, wr: 1'b0, out: 1'b0, jmp: JMP_NEXT, target: ST_IDLE};
        case (s)
            ST_IDLE: begin
                u.asel   = ASEL_IN;
                u.jmp    = JMP_ACCEPT;
                u.target = ST_CUR;
            end
            ST_CUR: begin
                u.asel    = ASEL_NBR;
                u.nbr     = FACE_TOP;
                u.cap_cur = 1'b1;
                u.jmp     = JMP_MODE;
            end
            ST_TOP: begin
                u.asel     = ASEL_NBR;
                u.nbr      = FACE_BOT;
                u.cap_face = 1'b1;
                u.face     = FACE_TOP;
            end
            ST_BOT: begin
                u.asel     = ASEL_NBR;
                u.nbr      = FACE_PX;
                u.cap_face = 1'b1;
                u.face     = FACE_BOT;
            end
            ST_PX: begin
                u.asel     = ASEL_NBR;
                u.nbr      = FACE_NX;
                u.cap_face = 1'b1;
                u.face     = FACE_PX;
            end
            ST_NX: begin
                u.asel     = ASEL_NBR;
                u.nbr      = FACE_PZ;
                u.cap_face = 1'b1;
                u.face     = FACE_NX;
            end
            ST_PZ: begin
                u.asel     = ASEL_NBR;
                u.nbr      = FACE_NZ;
                u.cap_face = 1'b1;
                u.face     = FACE_PZ;
            end
            ST_NZ: begin
                u.cap_face = 1'b1;
                u.face     = FACE_NZ;
                u.jmp      = JMP_GOTO;
                u.target   = ST_OUT;
            end
            ST_WR: begin
                u.wr     = 1'b1;
                u.jmp    = JMP_GOTO;
                u.target = ST_OUT;
            end
            ST_OUT: begin
                u.out    = 1'b1;
                u.jmp    = JMP_OUT;
                u.target = ST_IDLE;
            end
            default: begin
                u.jmp    = JMP_GOTO;
                u.target = ST_IDLE;
            end
        endcase
        return u;
    endfunction

    function automatic t_addr cell_index(logic [XZ_W-1:0] x, logic [Y_W-1:0] y,
                                         logic [XZ_W-1:0] z);
        int a;
        a = int'(x) * XZ_SIZE + int'(z) + int'(y) * XZ_SIZE * XZ_SIZE;
        return ADDR_W'(a);
    endfunction

endpackage

>>> design/vgfc_item_if.sv
interface vgfc_item_if;
    logic                        valid;
    logic                        ready;
    logic [vgfc_pkg::MODE_W-1:0] mode;
    logic [vgfc_pkg::CX_W-1:0]   coord_x;
    logic [vgfc_pkg::CY_W-1:0]   coord_y;
    logic [vgfc_pkg::CZ_W-1:0]   coord_z;
    logic [vgfc_pkg::MAT_W-1:0]  material;

    modport source (output valid, mode, coord_x, coord_y, coord_z, material, input ready);
    modport sink   (input valid, mode, coord_x, coord_y, coord_z, material, output ready);
endinterface

>>> design/vgfc_result_if.sv
interface vgfc_result_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [vgfc_pkg::IDX_W-1:0]  cell_index;
    logic [vgfc_pkg::MAT_W-1:0]  cell_material;
    logic [vgfc_pkg::MASK_W-1:0] face_mask;

    modport source (output valid, status, cell_index, cell_material, face_mask, input ready);
    modport sink   (input valid, status, cell_index, cell_material, face_mask, output ready);
endinterface

>>> design/vgfc_cfg_if.sv
interface vgfc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [vgfc_pkg::CFG_IDX_W-1:0] index;
    logic [vgfc_pkg::MAT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/voxel_grid_face_culling.sv
// Voxel grid with visible-face culling.
// i_item (valid/ready) takes one transaction per operation: place, remove,
// query or plain read of one cell. o_result (valid/ready) returns exactly one
// transaction per item: status, linear cell index, material, face mask.
// i_cfg (valid/ready, always ready) writes the empty and water codes; write
// only while no item is in flight.
// A microcode step counter drives one single-port cell memory; every read
// costs one step, so the port sets the rate.
// Steps after accept: read CUR, OUT; place/remove CUR, WR, OUT; query CUR,
// TOP, BOT, PX, NX, PZ, NZ, OUT. A new item is accepted only back in IDLE.
// Reset: after i_rst_n is released the memory is cleared one cell a cycle,
// all CELL_COUNT (32768) cells, with i_item.ready low; i_cfg writes are taken.
// A finished result sits in the output register; the next item is accepted
// meanwhile, and the sequencer holds at its output step only if the
// receiver has not taken the previous result.
module voxel_grid_face_culling (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    vgfc_item_if.sink            i_item,
    vgfc_result_if.source        o_result,
    vgfc_cfg_if.sink             i_cfg
);

    vgfc_pkg::t_step             r_step;
    vgfc_pkg::t_step             n_step;
    vgfc_pkg::t_uop              uop;

    vgfc_pkg::t_mode             r_mode;
    logic [vgfc_pkg::XZ_W-1:0]   r_x;
    logic [vgfc_pkg::Y_W-1:0]    r_y;
    logic [vgfc_pkg::XZ_W-1:0]   r_z;
    logic [vgfc_pkg::MAT_W-1:0]  r_mat;
    logic [vgfc_pkg::MAT_W-1:0]  r_cur;
    logic [vgfc_pkg::MAT_W-1:0]  r_rdata;
    logic [vgfc_pkg::MASK_W-1:0] r_mask;
    logic [vgfc_pkg::MAT_W-1:0]  r_empty;
    logic [vgfc_pkg::MAT_W-1:0]  r_water;

    logic                        r_clearing;
    vgfc_pkg::t_addr             r_clr_addr;

    logic                        r_out_valid;
    logic                        r_out_status;
    logic [vgfc_pkg::IDX_W-1:0]  r_out_idx;
    logic [vgfc_pkg::MAT_W-1:0]  r_out_mat;
    logic [vgfc_pkg::MASK_W-1:0] r_out_mask;

    logic [vgfc_pkg::MAT_W-1:0]  mem [vgfc_pkg::CELL_COUNT];

    vgfc_pkg::t_nbr              nbr;
    logic [vgfc_pkg::XZ_W-1:0]   in_x;
    logic [vgfc_pkg::Y_W-1:0]    in_y;
    logic [vgfc_pkg::XZ_W-1:0]   in_z;
    vgfc_pkg::t_addr             in_addr;

    logic                        accept;
    logic                        out_free;
    logic                        cur_empty;
    logic                        refused;
    logic                        face_bit;
    logic                        load_out;
    logic                        mem_we;
    vgfc_pkg::t_addr             mem_addr;
    logic [vgfc_pkg::MAT_W-1:0]  mem_wdata;
    logic [vgfc_pkg::MAT_W-1:0]  res_mat;

    vgfc_addr_gen u_addr_gen (
        .i_x   (r_x),
        .i_y   (r_y),
        .i_z   (r_z),
        .o_nbr (nbr)
    );

    assign uop      = vgfc_pkg::uop_rom(r_step);
    assign accept   = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_result.ready;

    assign in_x    = vgfc_pkg::XZ_W'(i_item.coord_x % vgfc_pkg::XZ_SIZE);
    assign in_y    = vgfc_pkg::Y_W'(i_item.coord_y % vgfc_pkg::Y_SIZE);
    assign in_z    = vgfc_pkg::XZ_W'(i_item.coord_z % vgfc_pkg::XZ_SIZE);
    assign in_addr = vgfc_pkg::cell_index(in_x, in_y, in_z);

    assign i_item.ready = !r_clearing && (r_step == vgfc_pkg::ST_IDLE);
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid         = r_out_valid;
    assign o_result.status        = r_out_status;
    assign o_result.cell_index    = r_out_idx;
    assign o_result.cell_material = r_out_mat;
    assign o_result.face_mask     = r_out_mask;

    // next step
    always_comb begin
        n_step = r_step;
        if (r_clearing) begin
            n_step = vgfc_pkg::ST_IDLE;
        end else begin
            case (uop.jmp)
                vgfc_pkg::JMP_NEXT:   n_step = vgfc_pkg::t_step'(r_step + 4'd1);
                vgfc_pkg::JMP_ACCEPT: n_step = accept ? uop.target : r_step;
                vgfc_pkg::JMP_MODE: begin
                    if (r_mode == vgfc_pkg::MODE_QUERY) begin
                        n_step = vgfc_pkg::ST_TOP;
                    end else if (r_mode inside {vgfc_pkg::MODE_PLACE,
                                                vgfc_pkg::MODE_REMOVE}) begin
                        n_step = vgfc_pkg::ST_WR;
                    end else begin
                        n_step = vgfc_pkg::ST_OUT;
                    end
                end
                vgfc_pkg::JMP_GOTO:   n_step = uop.target;
                vgfc_pkg::JMP_OUT:    n_step = out_free ? uop.target : r_step;
                default:              n_step = vgfc_pkg::ST_IDLE;
            endcase
        end
    end

    // datapath control
    always_comb begin
        cur_empty = (r_cur == r_empty);
        refused   = ((r_mode == vgfc_pkg::MODE_PLACE) && !cur_empty) ||
                    ((r_mode == vgfc_pkg::MODE_REMOVE) && cur_empty);

        face_bit = (nbr.inb[uop.face] &&
                    ((r_rdata == r_empty) || ((r_cur != r_water) && (r_rdata == r_water)))) ||
                   ((uop.face == vgfc_pkg::FACE_TOP) && nbr.top_edge);

        load_out = uop.out && out_free && !r_clearing;

        if (refused) begin
            res_mat = r_cur;
        end else begin
            case (r_mode)
                vgfc_pkg::MODE_PLACE:  res_mat = r_mat;
                vgfc_pkg::MODE_REMOVE: res_mat = r_empty;
                default:               res_mat = r_cur;
            endcase
        end

        if (r_clearing) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = uop.wr && !refused;
            mem_wdata = (r_mode == vgfc_pkg::MODE_PLACE) ? r_mat : r_empty;
            case (uop.asel)
                vgfc_pkg::ASEL_IN:  mem_addr = in_addr;
                vgfc_pkg::ASEL_NBR: mem_addr = nbr.addr[uop.nbr];
                default:            mem_addr = nbr.ctr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= vgfc_pkg::ST_IDLE;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_empty     <= '0;
            r_water     <= vgfc_pkg::MAT_W'(1);
        end else begin
            r_step <= n_step;
            if (r_clearing) begin
                r_clr_addr <= vgfc_pkg::ADDR_W'(r_clr_addr + 1'b1);
                if (r_clr_addr == vgfc_pkg::ADDR_W'(vgfc_pkg::CELL_COUNT - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    vgfc_pkg::CFG_EMPTY: r_empty <= i_cfg.data;
                    vgfc_pkg::CFG_WATER: r_water <= i_cfg.data;
                    default: ;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= vgfc_pkg::t_mode'(i_item.mode);
            r_x    <= in_x;
            r_y    <= in_y;
            r_z    <= in_z;
            r_mat  <= i_item.material;
            r_mask <= '0;
        end
        if (uop.cap_cur) begin
            r_cur <= r_rdata;
        end
        if (uop.cap_face) begin
            r_mask[uop.face] <= face_bit;
        end
        if (load_out) begin
            r_out_status <= refused;
            r_out_idx    <= vgfc_pkg::IDX_W'(nbr.ctr);
            r_out_mat    <= res_mat;
            r_out_mask   <= ((r_mode == vgfc_pkg::MODE_QUERY) && !cur_empty) ? r_mask : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end else begin
            r_rdata <= mem[mem_addr];
        end
    end

endmodule

>>> design/vgfc_addr_gen.sv
module vgfc_addr_gen (
    input  logic [vgfc_pkg::XZ_W-1:0] i_x,
    input  logic [vgfc_pkg::Y_W-1:0]  i_y,
    input  logic [vgfc_pkg::XZ_W-1:0] i_z,
    output vgfc_pkg::t_nbr            o_nbr
);

    vgfc_pkg::t_addr ctr;

    always_comb begin
        ctr       = vgfc_pkg::cell_index(i_x, i_y, i_z);
        o_nbr.ctr = ctr;

        o_nbr.addr[vgfc_pkg::FACE_TOP] = vgfc_pkg::ADDR_W'(
            ctr + vgfc_pkg::ADDR_W'(vgfc_pkg::XZ_SIZE * vgfc_pkg::XZ_SIZE));
        o_nbr.addr[vgfc_pkg::FACE_BOT] = vgfc_pkg::ADDR_W'(
            ctr - vgfc_pkg::ADDR_W'(vgfc_pkg::XZ_SIZE * vgfc_pkg::XZ_SIZE));
        o_nbr.addr[vgfc_pkg::FACE_PX]  = vgfc_pkg::ADDR_W'(
            ctr + vgfc_pkg::ADDR_W'(vgfc_pkg::XZ_SIZE));
        o_nbr.addr[vgfc_pkg::FACE_NX]  = vgfc_pkg::ADDR_W'(
            ctr - vgfc_pkg::ADDR_W'(vgfc_pkg::XZ_SIZE));
        o_nbr.addr[vgfc_pkg::FACE_PZ]  = vgfc_pkg::ADDR_W'(ctr + vgfc_pkg::ADDR_W'(1));
        o_nbr.addr[vgfc_pkg::FACE_NZ]  = vgfc_pkg::ADDR_W'(ctr - vgfc_pkg::ADDR_W'(1));

        o_nbr.inb[vgfc_pkg::FACE_TOP] = (i_y != vgfc_pkg::Y_W'(vgfc_pkg::Y_SIZE - 1));
        o_nbr.inb[vgfc_pkg::FACE_BOT] = (i_y != '0);
        o_nbr.inb[vgfc_pkg::FACE_PX]  = (i_x != vgfc_pkg::XZ_W'(vgfc_pkg::XZ_SIZE - 1));
        o_nbr.inb[vgfc_pkg::FACE_NX]  = (i_x != '0);
        o_nbr.inb[vgfc_pkg::FACE_PZ]  = (i_z != vgfc_pkg::XZ_W'(vgfc_pkg::XZ_SIZE - 1));
        o_nbr.inb[vgfc_pkg::FACE_NZ]  = (i_z != '0);

        o_nbr.top_edge = (i_y == vgfc_pkg::Y_W'(vgfc_pkg::Y_SIZE - 1));
    end

endmodule

>>> design/vgfc_checker.sv
module vgfc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_item_valid,
    input logic                        i_item_ready,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic                        i_res_status,
    input logic [vgfc_pkg::IDX_W-1:0]  i_res_index,
    input logic [vgfc_pkg::MAT_W-1:0]  i_res_material,
    input logic [vgfc_pkg::MASK_W-1:0] i_res_mask
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_valid && i_item_ready |=> !i_item_ready)
        else $error("item accepted while previous item still in work");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_item_ready && !i_res_valid)
        else $error("channels active right after reset");

    a_refused_no_faces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_status |-> i_res_mask == '0)
        else $error("refused result carries a face mask");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_status) &&
            $stable(i_res_index) && $stable(i_res_material) && $stable(i_res_mask))
        else $error("stalled result changed");

endmodule

bind voxel_grid_face_culling vgfc_checker u_vgfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_item_valid   (i_item.valid),
    .i_item_ready   (i_item.ready),
    .i_res_valid    (o_result.valid),
    .i_res_ready    (o_result.ready),
    .i_res_status   (o_result.status),
    .i_res_index    (o_result.cell_index),
    .i_res_material (o_result.cell_material),
    .i_res_mask     (o_result.face_mask)
);

>>> sim/voxel_grid_face_culling_tb.sv
module voxel_grid_face_culling_tb;
    import vgfc_pkg::*;

    localparam int IDLE_PCT    = 18;
    localparam int HOLD_AT     = 900;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 120000;
    localparam int PHASE_OPS   = 420;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_mode            mode;
        logic [CX_W-1:0]  x;
        logic [CY_W-1:0]  y;
        logic [CZ_W-1:0]  z;
        logic [MAT_W-1:0] material;
    } t_cell_op;

    typedef struct packed {
        logic              status;
        logic [IDX_W-1:0]  cell_index;
        logic [MAT_W-1:0]  cell_material;
        logic [MASK_W-1:0] face_mask;
    } t_cell_reply;

    class t_voxel_shadow;
        logic [MAT_W-1:0] cells [CELL_COUNT];
        logic [MAT_W-1:0] empty_code;
        logic [MAT_W-1:0] water_code;
        t_cell_reply      replies_due [$];
        int               mismatches;

        function new();
            foreach (cells[i]) cells[i] = '0;
            empty_code = 7'd0;
            water_code = 7'd1;
            mismatches = 0;
        endfunction

        function void set_code(t_cfg_idx idx, logic [MAT_W-1:0] value);
            if (idx == CFG_EMPTY)
                empty_code = value;
            else if (idx == CFG_WATER)
                water_code = value;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function bit opens_face(int x, int y, int z, bit wet);
            logic [MAT_W-1:0] m;
            if (x < 0 || y < 0 || z < 0 || x >= XZ_SIZE || y >= Y_SIZE || z >= XZ_SIZE)
                return 1'b0;
            m = cells[x * XZ_SIZE + z + y * XZ_SIZE * XZ_SIZE];
            if (m == empty_code)
                return 1'b1;
            return !wet && m == water_code;
        endfunction

        function void take_op(t_cell_op op);
            int               x;
            int               y;
            int               z;
            int               slot;
            logic [MAT_W-1:0] here;
            bit               wet;
            t_cell_reply      want;
            x    = int'(op.x) % XZ_SIZE;
            y    = int'(op.y) % Y_SIZE;
            z    = int'(op.z) % XZ_SIZE;
            slot = x * XZ_SIZE + z + y * XZ_SIZE * XZ_SIZE;
            here = cells[slot];
            want = '0;
            case (op.mode)
                MODE_PLACE: begin
                    if (here != empty_code)
                        want.status = 1'b1;
                    else
                        cells[slot] = op.material;
                end
                MODE_REMOVE: begin
                    if (here == empty_code)
                        want.status = 1'b1;
                    else
                        cells[slot] = empty_code;
                end
                MODE_QUERY: begin
                    if (here != empty_code) begin
                        wet = (here == water_code);
                        want.face_mask[FACE_TOP] = opens_face(x, y + 1, z, wet) ||
                                                   y == Y_SIZE - 1;
                        want.face_mask[FACE_BOT] = opens_face(x, y - 1, z, wet);
                        want.face_mask[FACE_PX]  = opens_face(x + 1, y, z, wet);
                        want.face_mask[FACE_NX]  = opens_face(x - 1, y, z, wet);
                        want.face_mask[FACE_PZ]  = opens_face(x, y, z + 1, wet);
                        want.face_mask[FACE_NZ]  = opens_face(x, y, z - 1, wet);
                    end
                end
                default: ;
            endcase
            want.cell_index    = IDX_W'(slot);
            want.cell_material = cells[slot];
            replies_due = {replies_due, want};
        endfunction

        function void check_reply(t_cell_reply got);
            t_cell_reply want;
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb: unexpected result st=%0d idx=%0d mat=%0d faces=%b",
                             got.status, got.cell_index, got.cell_material, got.face_mask);
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status || got.cell_index !== want.cell_index ||
                got.cell_material !== want.cell_material ||
                got.face_mask !== want.face_mask) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb: mismatch exp %0d/%0d/%0d/%b got %0d/%0d/%0d/%b",
                             want.status, want.cell_index, want.cell_material,
                             want.face_mask, got.status, got.cell_index,
                             got.cell_material, got.face_mask);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    vgfc_item_if   item_bus ();
    vgfc_result_if res_bus ();
    vgfc_cfg_if    cfg_bus ();

    voxel_grid_face_culling u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (res_bus),
        .i_cfg    (cfg_bus)
    );

    t_voxel_shadow    grid;
    logic             calm;
    int               items_in    = 0;
    int               hold_left   = 0;
    bit               hold_done   = 1'b0;
    int               quiet_cycles = 0;
    int               win_x;
    int               win_y;
    int               win_z;
    logic [MAT_W-1:0] palette [3];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Track every transaction on the three channels.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (cfg_bus.valid && cfg_bus.ready)
                grid.set_code(t_cfg_idx'(cfg_bus.index), cfg_bus.data);
            if (res_bus.valid && res_bus.ready)
                grid.check_reply({res_bus.status, res_bus.cell_index,
                                  res_bus.cell_material, res_bus.face_mask});
            if (item_bus.valid && item_bus.ready) begin
                grid.take_op({t_mode'(item_bus.mode), item_bus.coord_x, item_bus.coord_y,
                              item_bus.coord_z, item_bus.material});
                items_in <= items_in + 1;
            end
        end
    end

    // Result side: random back-pressure plus one long hold-off.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            res_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && items_in >= HOLD_AT) begin
            res_bus.ready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end else begin
            res_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_op(t_cell_op op);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            item_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_bus.valid    <= 1'b1;
        item_bus.mode     <= op.mode;
        item_bus.coord_x  <= op.x;
        item_bus.coord_y  <= op.y;
        item_bus.coord_z  <= op.z;
        item_bus.material <= op.material;
        do @(posedge i_clk); while (item_bus.ready !== 1'b1);
    endtask

    task automatic do_op(t_mode mode, int x, int y, int z, int material);
        t_cell_op op;
        op.mode     = mode;
        op.x        = CX_W'(x);
        op.y        = CY_W'(y);
        op.z        = CZ_W'(z);
        op.material = MAT_W'(material);
        send_op(op);
    endtask

    task automatic write_codes(logic [MAT_W-1:0] empty_val, logic [MAT_W-1:0] water_val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= CFG_EMPTY;
        cfg_bus.data  <= empty_val;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        cfg_bus.index <= CFG_WATER;
        cfg_bus.data  <= water_val;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid and wait until every outstanding transaction has come back.
    task automatic settle();
        item_bus.valid <= 1'b0;
        while (grid.pending() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    function automatic int pick_base(int span);
        case ($urandom_range(2))
            0: return 0;
            1: return span;
            default: return $urandom_range(span);
        endcase
    endfunction

    // Most operations land in a small window so that cells get neighbors.
    function automatic t_cell_op pick_op();
        t_cell_op op;
        int       r;
        r = $urandom_range(99);
        if (r < 40)
            op.mode = MODE_PLACE;
        else if (r < 62)
            op.mode = MODE_REMOVE;
        else if (r < 92)
            op.mode = MODE_QUERY;
        else
            op.mode = MODE_READ;
        if ($urandom_range(99) < 80) begin
            op.x = CX_W'(win_x + $urandom_range(3));
            op.z = CZ_W'(win_z + $urandom_range(3));
            r = $urandom_range(99);
            if (r < 35)
                op.y = CY_W'($urandom_range(3));
            else if (r < 70)
                op.y = CY_W'(Y_SIZE - 4 + $urandom_range(3));
            else
                op.y = CY_W'(win_y + $urandom_range(3));
        end else begin
            op.x = CX_W'($urandom_range(XZ_SIZE - 1));
            op.y = CY_W'($urandom_range(Y_SIZE - 1));
            op.z = CZ_W'($urandom_range(XZ_SIZE - 1));
        end
        r = $urandom_range(99);
        if (r < 10)
            op.material = grid.empty_code;
        else if (r < 35)
            op.material = grid.water_code;
        else if (r < 75)
            op.material = palette[$urandom_range(2)];
        else
            op.material = MAT_W'($urandom_range(127));
        return op;
    endfunction

    initial begin
        int k;
        int n;
        grid = new();
        i_rst_n           <= 1'b0;
        calm              <= 1'b0;
        item_bus.valid    <= 1'b0;
        item_bus.mode     <= MODE_PLACE;
        item_bus.coord_x  <= '0;
        item_bus.coord_y  <= '0;
        item_bus.coord_z  <= '0;
        item_bus.material <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= CFG_EMPTY;
        cfg_bus.data      <= '0;
        palette[0] = 7'h2A;
        palette[1] = 7'h55;
        palette[2] = 7'h7E;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_codes(7'd0, 7'd1);

        do_op(MODE_PLACE,   0,   0,  0,   9);
        do_op(MODE_PLACE,   0,   0,  0,   3);
        do_op(MODE_QUERY,   0,   0,  0,   0);
        do_op(MODE_PLACE,   1,   0,  0,   1);
        do_op(MODE_PLACE,   0,   1,  0,   0);
        do_op(MODE_QUERY,   0,   0,  0,   0);
        do_op(MODE_QUERY,   1,   0,  0, 127);
        do_op(MODE_PLACE,  15, 127, 15, 127);
        do_op(MODE_QUERY,  15, 127, 15,   0);
        do_op(MODE_PLACE,  15, 126, 15,   1);
        do_op(MODE_QUERY,  15, 127, 15,   0);
        do_op(MODE_QUERY,  15, 126, 15,   0);
        do_op(MODE_REMOVE, 15, 126, 15,   0);
        do_op(MODE_REMOVE, 15, 126, 15,   0);
        do_op(MODE_READ,   15, 127, 15,   0);
        do_op(MODE_READ,    7,  64,  7,   0);
        do_op(MODE_QUERY,   7,  64,  7,   0);
        do_op(MODE_REMOVE,  0,   0,  0,   0);
        do_op(MODE_QUERY,   1,   0,  0,   0);
        do_op(MODE_PLACE,   8, 127,  8,   1);
        do_op(MODE_QUERY,   8, 127,  8,   0);
        do_op(MODE_PLACE,  10,  85,  5,  85);
        do_op(MODE_QUERY,  10,  85,  5,   0);

        for (k = 0; k < 4; k++) begin
            settle();
            case (k)
                0: write_codes(7'd0, 7'd127);
                1: write_codes(7'd127, 7'd0);
                2: write_codes(7'h2A, 7'h2A);
                default: write_codes(MAT_W'($urandom_range(127)),
                                     MAT_W'($urandom_range(127)));
            endcase
            for (n = 0; n < PHASE_OPS; n++) begin
                if (n % 105 == 0) begin
                    win_x = pick_base(XZ_SIZE - 4);
                    win_z = pick_base(XZ_SIZE - 4);
                    win_y = pick_base(Y_SIZE - 4);
                end
                calm <= (k == 1 && n >= 100 && n < 260);
                send_op(pick_op());
            end
        end
        settle();

        if (grid.mismatches == 0 && grid.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
design/vgfc_pkg.sv
design/vgfc_item_if.sv
design/vgfc_result_if.sv
design/vgfc_cfg_if.sv
design/vgfc_addr_gen.sv
design/voxel_grid_face_culling.sv
design/vgfc_checker.sv
sim/voxel_grid_face_culling_tb.sv
